// ----- hw/rtl/qau_pkg.sv -----
// ----------------------------------------------------------------------------
// qau_pkg: shared types and codes for the quaternion arithmetic unit
// Command codes, the input and result beat types, and the class tags that the
// front end attaches to each command before it is queued for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

package qau_pkg;

    // Command codes
    localparam logic [2:0] CMD_PRODUCT = 3'd0;
    localparam logic [2:0] CMD_ROTATE  = 3'd1;
    localparam logic [2:0] CMD_SUM     = 3'd2;
    localparam logic [2:0] CMD_DIFF    = 3'd3;
    localparam logic [2:0] CMD_SCALE   = 3'd4;
    localparam logic [2:0] CMD_CONJ    = 3'd5;
    localparam logic [2:0] CMD_DOT     = 3'd6;
    localparam logic [2:0] CMD_NORM    = 3'd7;

    // Command queue between front and back end
    localparam int QDEPTH = 4;
    localparam int QAW    = 2;

    typedef struct packed {
        logic [2:0]         command;
        logic signed [31:0] a_w;
        logic signed [31:0] a_x;
        logic signed [31:0] a_y;
        logic signed [31:0] a_z;
        logic signed [31:0] b_w;
        logic signed [31:0] b_x;
        logic signed [31:0] b_y;
        logic signed [31:0] b_z;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] r_w;
        logic signed [31:0] r_x;
        logic signed [31:0] r_y;
        logic signed [31:0] r_z;
        logic               overflow;
    } t_out_item;

    // Which datapath of the back end finishes the command
    typedef struct packed {
        logic lin;   // sum, difference, conjugate
        logic quad;  // product, scale, dot
        logic rot;   // vector rotation
        logic norm;  // Euclidean norm
    } t_cls;

    typedef struct packed {
        t_in_item item;
        t_cls     cls;
    } t_task;

endpackage

`default_nettype wire

// ----- hw/rtl/qau_front.sv -----
// ----------------------------------------------------------------------------
// qau_front: command intake
// Registers each input beat, tags it with the datapath that will finish it,
// and hands it to the command queue.
// ----------------------------------------------------------------------------
`default_nettype none

module qau_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  qau_pkg::t_in_item i_data,
    output logic              o_task_valid,
    input  logic              i_task_ready,
    output qau_pkg::t_task    o_task
);
    import qau_pkg::*;

    logic   r_v;
    t_task  r_task;
    t_cls   n_cls;

    // Classify the command
    always_comb begin
        n_cls = '0;
        case (i_data.command)
            CMD_SUM, CMD_DIFF, CMD_CONJ:     n_cls.lin  = 1'b1;
            CMD_PRODUCT, CMD_SCALE, CMD_DOT: n_cls.quad = 1'b1;
            CMD_ROTATE:                      n_cls.rot  = 1'b1;
            CMD_NORM:                        n_cls.norm = 1'b1;
            default:                         n_cls.lin  = 1'b1;
        endcase
    end

    assign o_ready      = !r_v || i_task_ready;
    assign o_task_valid = r_v;
    assign o_task       = r_task;

    // Hold the beat until the queue takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (o_ready) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_task.item <= i_data;
            r_task.cls  <= n_cls;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/qau_queue.sv -----
// ----------------------------------------------------------------------------
// qau_queue: command queue
// Small FIFO that decouples the front end from the back-end pipeline so that
// either side can stall without stopping the other.
// ----------------------------------------------------------------------------
`default_nettype none

module qau_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push_valid,
    output logic           o_push_ready,
    input  qau_pkg::t_task i_push_data,
    output logic           o_pop_valid,
    input  logic           i_pop_ready,
    output qau_pkg::t_task o_pop_data
);
    import qau_pkg::*;

    t_task          r_mem [QDEPTH];
    logic [QAW-1:0] r_wr;
    logic [QAW-1:0] r_rd;
    logic [QAW:0]   r_cnt;
    logic           push;
    logic           pop;

    assign o_push_ready = (r_cnt != (QAW+1)'(QDEPTH));
    assign o_pop_valid  = (r_cnt != '0);
    assign o_pop_data   = r_mem[r_rd];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_push_data;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/qau_back.sv -----
// ----------------------------------------------------------------------------
// qau_back: arithmetic pipeline
// Multiplier bank, sum trees, rounding and saturation, split rotation
// products, and a one-step-per-stage square root pipeline. All stages advance
// together whenever the output register is free or being drained.
// ----------------------------------------------------------------------------
`default_nettype none

module qau_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_task_valid,
    output logic               o_task_ready,
    input  qau_pkg::t_task     i_task,
    output logic               o_valid,
    input  logic               i_ready,
    output qau_pkg::t_out_item o_data
);
    import qau_pkg::*;

    localparam int PW   = 66;
    localparam int WIDE = 104;
    localparam int NSQ  = 32;
    localparam logic signed [WIDE-1:0] MAXV   = WIDE'(64'd2147483647);
    localparam logic signed [WIDE-1:0] MINV   = ~MAXV;
    localparam logic signed [WIDE-1:0] HALF16 = WIDE'(64'd32768);
    localparam logic signed [WIDE-1:0] HALF32 = WIDE'(64'd2147483648);

    // Clamp to 32-bit signed, flag in the top bit
    function automatic logic [32:0] sat32(input logic signed [WIDE-1:0] v);
        logic [32:0] res;
        if (v > MAXV) begin
            res = {1'b1, 32'h7FFF_FFFF};
        end else if (v < MINV) begin
            res = {1'b1, 32'h8000_0000};
        end else begin
            res = {1'b0, v[31:0]};
        end
        return res;
    endfunction

    function automatic logic [32:0] sat33(input logic signed [32:0] e);
        logic [32:0] res;
        if (e[32] != e[31]) begin
            res = e[32] ? {1'b1, 32'h8000_0000} : {1'b1, 32'h7FFF_FFFF};
        end else begin
            res = {1'b0, e[31:0]};
        end
        return res;
    endfunction

    // Round half up by 16 fraction bits, then saturate
    function automatic logic [32:0] rnd16(input logic signed [PW-1:0] v);
        logic signed [WIDE-1:0] t;
        t = {{(WIDE-PW){v[PW-1]}}, v};
        t = t + HALF16;
        t = t >>> 16;
        return sat32(t);
    endfunction

    function automatic logic signed [PW-1:0] sx64(input logic signed [63:0] v);
        return {{(PW-64){v[63]}}, v};
    endfunction

    logic adv;

    // Stage 1: multiplier bank and the linear commands
    logic                r1_v;
    t_cls                r1_cls;
    logic [2:0]          r1_cmd;
    logic signed [63:0]  r1_p  [16];
    logic signed [31:0]  r1_bv [3];
    t_out_item           r1_res;

    logic signed [31:0]  opa [16];
    logic signed [31:0]  opb [16];
    logic signed [31:0]  la  [4];
    logic signed [31:0]  lb  [4];
    t_out_item           n1_res;

    // Stage 2: sum trees
    logic                r2_v;
    t_cls                r2_cls;
    logic [2:0]          r2_cmd;
    logic signed [PW-1:0] r2_l [4];
    logic signed [PW-1:0] r2_m [9];
    logic signed [31:0]  r2_bv [3];
    t_out_item           r2_res;

    logic signed [PW-1:0] n2_l [4];
    logic signed [PW-1:0] n2_m [9];

    // Rotation partial products, full products, row sums
    logic signed [64:0]   r3_pl  [9];
    logic signed [65:0]   r3_ph  [9];
    logic signed [WIDE-1:0] r4_mp [9];
    logic signed [WIDE-1:0] r5_acc [3];
    t_out_item           rot_res;

    // Square root chain; index 0 is the stage after the sum trees
    logic                r_sv   [NSQ+1];
    t_cls                r_scls [NSQ+1];
    t_out_item           r_sres [NSQ+1];
    logic [63:0]         r_sop  [NSQ+1];
    logic [63:0]         r_srt  [NSQ+1];
    logic                r_sbig [NSQ+1];
    logic [63:0]         n_sop  [NSQ];
    logic [63:0]         n_srt  [NSQ];
    t_out_item           n_sres [NSQ];
    t_out_item           q_res;

    // Output register
    logic                r_out_v;
    t_out_item           r_out;
    t_out_item           n_out;

    assign adv          = !r_out_v || i_ready;
    assign o_task_ready = adv;
    assign o_valid      = r_out_v;
    assign o_data       = r_out;

    // Route multiplier operands: rotation and norm take products of A with itself
    always_comb begin
        logic alt;
        logic [32:0] s;
        logic signed [32:0] ea;
        logic signed [32:0] eb;
        logic signed [32:0] e;
        alt = i_task.cls.rot || i_task.cls.norm;
        la[0] = i_task.item.a_w; la[1] = i_task.item.a_x;
        la[2] = i_task.item.a_y; la[3] = i_task.item.a_z;
        lb[0] = i_task.item.b_w; lb[1] = i_task.item.b_x;
        lb[2] = i_task.item.b_y; lb[3] = i_task.item.b_z;

        opa[0]  = la[0];              opb[0]  = alt ? la[0] : lb[0];
        opa[1]  = la[1];              opb[1]  = alt ? la[1] : lb[1];
        opa[2]  = la[2];              opb[2]  = alt ? la[2] : lb[2];
        opa[3]  = la[3];              opb[3]  = alt ? la[3] : lb[3];
        opa[4]  = alt ? la[1] : la[0]; opb[4]  = alt ? la[2] : lb[1];
        opa[5]  = la[1];              opb[5]  = alt ? la[3] : lb[0];
        opa[6]  = la[2];              opb[6]  = alt ? la[3] : lb[3];
        opa[7]  = alt ? la[0] : la[3]; opb[7]  = alt ? la[1] : lb[2];
        opa[8]  = la[0];              opb[8]  = alt ? la[2] : lb[2];
        opa[9]  = alt ? la[0] : la[1]; opb[9]  = alt ? la[3] : lb[3];
        opa[10] = la[2];              opb[10] = lb[0];
        opa[11] = la[3];              opb[11] = lb[1];
        opa[12] = la[0];              opb[12] = lb[3];
        opa[13] = la[1];              opb[13] = lb[2];
        opa[14] = la[2];              opb[14] = lb[1];
        opa[15] = la[3];              opb[15] = lb[0];

        // Sum, difference, conjugate: one 33-bit add per lane
        n1_res = '0;
        for (int c = 0; c < 4; c++) begin
            ea = {la[c][31], la[c]};
            eb = {lb[c][31], lb[c]};
            case (i_task.item.command)
                CMD_SUM:  e = ea + eb;
                CMD_DIFF: e = ea - eb;
                default:  e = (c == 0) ? ea : (33'sd0 - ea);
            endcase
            s = sat33(e);
            case (c)
                0:       n1_res.r_w = s[31:0];
                1:       n1_res.r_x = s[31:0];
                2:       n1_res.r_y = s[31:0];
                default: n1_res.r_z = s[31:0];
            endcase
            n1_res.overflow = n1_res.overflow | s[32];
        end
    end

    // Sum trees for product, dot, scale, norm and the rotation matrix
    always_comb begin
        logic signed [PW-1:0] p [16];
        for (int k = 0; k < 16; k++) begin
            p[k] = sx64(r1_p[k]);
        end
        if (r1_cmd == CMD_SCALE) begin
            n2_l[0] = p[0];
            n2_l[1] = p[5];
            n2_l[2] = p[10];
            n2_l[3] = p[15];
        end else begin
            n2_l[0] = (r1_cmd == CMD_PRODUCT) ? (p[0] - p[1] - p[2] - p[3])
                                              : (p[0] + p[1] + p[2] + p[3]);
            n2_l[1] = p[4] + p[5] + p[6] - p[7];
            n2_l[2] = p[8] - p[9] + p[10] + p[11];
            n2_l[3] = p[12] + p[13] - p[14] + p[15];
        end
        // ww xx yy zz xy xz yz wx wy wz sit in products 0 to 9
        n2_m[0] = p[0] + p[1] - p[2] - p[3];
        n2_m[1] = (p[4] - p[9]) <<< 1;
        n2_m[2] = (p[5] + p[8]) <<< 1;
        n2_m[3] = (p[4] + p[9]) <<< 1;
        n2_m[4] = p[0] - p[1] + p[2] - p[3];
        n2_m[5] = (p[6] - p[7]) <<< 1;
        n2_m[6] = (p[5] - p[8]) <<< 1;
        n2_m[7] = (p[6] + p[7]) <<< 1;
        n2_m[8] = p[0] - p[1] - p[2] + p[3];
    end

    // Round and saturate the quadratic results; linear results pass through
    always_comb begin
        logic [32:0] s0;
        logic [32:0] s1;
        logic [32:0] s2;
        logic [32:0] s3;
        s0 = rnd16(r2_l[0]);
        s1 = rnd16(r2_l[1]);
        s2 = rnd16(r2_l[2]);
        s3 = rnd16(r2_l[3]);
        q_res = '0;
        if (r2_cls.lin) begin
            q_res = r2_res;
        end else if (r2_cls.quad) begin
            q_res.r_w      = s0[31:0];
            q_res.overflow = s0[32];
            if (r2_cmd != CMD_DOT) begin
                q_res.r_x      = s1[31:0];
                q_res.r_y      = s2[31:0];
                q_res.r_z      = s3[31:0];
                q_res.overflow = s0[32] | s1[32] | s2[32] | s3[32];
            end
        end
    end

    // Round the rotated vector by 32 bits and saturate
    always_comb begin
        logic signed [WIDE-1:0] t;
        logic [32:0] s;
        rot_res = '0;
        for (int i = 0; i < 3; i++) begin
            t = r5_acc[i] + HALF32;
            t = t >>> 32;
            s = sat32(t);
            case (i)
                0:       rot_res.r_x = s[31:0];
                1:       rot_res.r_y = s[31:0];
                default: rot_res.r_z = s[31:0];
            endcase
            rot_res.overflow = rot_res.overflow | s[32];
        end
    end

    // One square root step per stage; rotation result joins at stage three
    always_comb begin
        logic [63:0] bitk;
        logic [63:0] trial;
        for (int k = 0; k < NSQ; k++) begin
            bitk  = 64'd1 << (62 - 2*k);
            trial = r_srt[k] + bitk;
            if (r_sop[k] >= trial) begin
                n_sop[k] = r_sop[k] - trial;
                n_srt[k] = (r_srt[k] >> 1) + bitk;
            end else begin
                n_sop[k] = r_sop[k];
                n_srt[k] = r_srt[k] >> 1;
            end
            if (k == 2 && r_scls[k].rot) begin
                n_sres[k] = rot_res;
            end else begin
                n_sres[k] = r_sres[k];
            end
        end
    end

    // Pick the norm at the end of the chain
    always_comb begin
        n_out = r_sres[NSQ];
        if (r_scls[NSQ].norm) begin
            n_out = '0;
            if (r_sbig[NSQ] || (r_srt[NSQ] > 64'h0000_0000_7FFF_FFFF)) begin
                n_out.r_w      = 32'h7FFF_FFFF;
                n_out.overflow = 1'b1;
            end else begin
                n_out.r_w = r_srt[NSQ][31:0];
            end
        end
    end

    // Advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v    <= 1'b0;
            r2_v    <= 1'b0;
            r_out_v <= 1'b0;
            for (int k = 0; k <= NSQ; k++) begin
                r_sv[k] <= 1'b0;
            end
        end else if (adv) begin
            r1_v    <= i_task_valid;
            r2_v    <= r1_v;
            r_sv[0] <= r2_v;
            for (int k = 0; k < NSQ; k++) begin
                r_sv[k+1] <= r_sv[k];
            end
            r_out_v <= r_sv[NSQ];
        end
    end

    // Advance payload
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r1_cls <= i_task.cls;
            r1_cmd <= i_task.item.command;
            r1_res <= n1_res;
            for (int k = 0; k < 16; k++) begin
                r1_p[k] <= opa[k] * opb[k];
            end
            r1_bv[0] <= i_task.item.b_x;
            r1_bv[1] <= i_task.item.b_y;
            r1_bv[2] <= i_task.item.b_z;

            r2_cls <= r1_cls;
            r2_cmd <= r1_cmd;
            r2_res <= r1_res;
            r2_l   <= n2_l;
            r2_m   <= n2_m;
            r2_bv  <= r1_bv;

            for (int k = 0; k < 9; k++) begin
                r3_pl[k] <= $signed({1'b0, r2_m[k][31:0]}) * r2_bv[k % 3];
                r3_ph[k] <= $signed(r2_m[k][65:32]) * r2_bv[k % 3];
                r4_mp[k] <= ({{(WIDE-66){r3_ph[k][65]}}, r3_ph[k]} <<< 32)
                            + {{(WIDE-65){r3_pl[k][64]}}, r3_pl[k]};
            end
            for (int i = 0; i < 3; i++) begin
                r5_acc[i] <= r4_mp[3*i] + r4_mp[3*i+1] + r4_mp[3*i+2];
            end

            r_scls[0] <= r2_cls;
            r_sres[0] <= q_res;
            r_sop[0]  <= r2_l[0][63:0];
            r_srt[0]  <= '0;
            r_sbig[0] <= (r2_l[0][65:64] != 2'b00);
            for (int k = 0; k < NSQ; k++) begin
                r_scls[k+1] <= r_scls[k];
                r_sres[k+1] <= n_sres[k];
                r_sop[k+1]  <= n_sop[k];
                r_srt[k+1]  <= n_srt[k];
                r_sbig[k+1] <= r_sbig[k];
            end

            r_out <= n_out;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/quaternion_arith_unit.sv -----
// ----------------------------------------------------------------------------
// quaternion_arith_unit: Q16.16 quaternion arithmetic unit
// Product, rotation, sum, difference, scale, conjugate, dot and norm with
// round-half-up, saturation and an overflow flag.
//
//   channel   direction  handshake            beat
//   input     in         i_valid / o_ready    i_data  (t_in_item)
//   result    out        o_valid / i_ready    o_data  (t_out_item)
//
// One command per cycle sustained while results are taken. Every command takes
// the same path from input beat to result: front register, the queue, two
// arithmetic stages, 33 square root stages, output register.
// Reset clears all valid bits and the queue.
// A stalled result holds the back-end pipeline; the front end and its
// four-entry queue keep taking beats until the queue fills.
// ----------------------------------------------------------------------------
`default_nettype none

module quaternion_arith_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  qau_pkg::t_in_item  i_data,
    output logic               o_valid,
    input  logic               i_ready,
    output qau_pkg::t_out_item o_data
);
    import qau_pkg::*;

    logic  f_valid;
    logic  f_ready;
    t_task f_task;
    logic  q_valid;
    logic  q_ready;
    t_task q_task;

    qau_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_data       (i_data),
        .o_task_valid (f_valid),
        .i_task_ready (f_ready),
        .o_task       (f_task)
    );

    qau_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (f_valid),
        .o_push_ready (f_ready),
        .i_push_data  (f_task),
        .o_pop_valid  (q_valid),
        .i_pop_ready  (q_ready),
        .o_pop_data   (q_task)
    );

    qau_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_task_valid (q_valid),
        .o_task_ready (q_ready),
        .i_task       (q_task),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_data       (o_data)
    );

endmodule

`default_nettype wire

// ----- verif/tb_quaternion_arith_unit.sv -----
// ----------------------------------------------------------------------------
// tb_quaternion_arith_unit: self-checking bench for the quaternion unit
// Drives a directed table and then random commands through the valid/ready
// input, predicts each result beat in wide exact arithmetic and compares it
// field by field against the oldest expected beat, under random idling.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_quaternion_arith_unit;
    import qau_pkg::*;

    localparam int  N_RANDOM    = 730;
    localparam int  CYCLE_LIMIT = 400000;

    typedef logic signed [127:0] t_wide;

    // One directed row: a command beat, and an optional typed-in result
    typedef struct {
        t_in_item  beat;
        logic      has_exp;
        t_out_item exp;
    } t_row;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_valid;
    logic      o_ready;
    t_in_item  i_data;
    logic      o_valid;
    logic      i_ready;
    t_out_item o_data;

    t_out_item result_q[$];
    int        err_count;
    int        cycle_count;
    int        send_idle_pct;
    int        recv_idle_pct;
    t_row      rows[$];

    quaternion_arith_unit u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

    // Clock, 2 ns period
    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    // Round half up by the given shift, then clamp to int32
    function automatic logic [31:0] round_sat(input t_wide v, input int sh,
                                              inout logic ovf);
        t_wide r;
        r = v;
        if (sh > 0) begin
            r = (r + (t_wide'(1) <<< (sh - 1))) >>> sh;
        end
        if (r > t_wide'(32'sh7FFFFFFF)) begin
            ovf = 1'b1;
            return 32'h7FFFFFFF;
        end
        if (r < -t_wide'(64'sh80000000)) begin
            ovf = 1'b1;
            return 32'h80000000;
        end
        return r[31:0];
    endfunction

    // Floor of the square root of a 128-bit non-negative value
    function automatic logic [63:0] floor_sqrt(input logic [127:0] op);
        logic [127:0] rem;
        logic [127:0] res;
        logic [127:0] bitv;
        rem  = op;
        res  = '0;
        bitv = 128'd1 << 126;
        while (bitv > rem) bitv >>= 2;
        while (bitv != 0) begin
            if (rem >= res + bitv) begin
                rem = rem - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res[63:0];
    endfunction

    // Quaternion unit predictor
    function automatic t_out_item quat_predict(input t_in_item c);
        t_out_item o;
        t_wide     w, x, y, z, bw, bx, by, bz;
        t_wide     m[3][3];
        t_wide     acc, sq;
        logic [63:0] root;
        logic      ovf;
        w  = c.a_w; x  = c.a_x; y  = c.a_y; z  = c.a_z;
        bw = c.b_w; bx = c.b_x; by = c.b_y; bz = c.b_z;
        ovf = 1'b0;
        o = '0;
        case (c.command)
            CMD_PRODUCT: begin
                o.r_w = round_sat(w*bw - x*bx - y*by - z*bz, 16, ovf);
                o.r_x = round_sat(w*bx + x*bw + y*bz - z*by, 16, ovf);
                o.r_y = round_sat(w*by - x*bz + y*bw + z*bx, 16, ovf);
                o.r_z = round_sat(w*bz + x*by - y*bx + z*bw, 16, ovf);
            end
            CMD_ROTATE: begin
                m[0][0] = w*w + x*x - y*y - z*z;
                m[0][1] = 2 * (x*y - w*z);
                m[0][2] = 2 * (x*z + w*y);
                m[1][0] = 2 * (x*y + w*z);
                m[1][1] = w*w - x*x + y*y - z*z;
                m[1][2] = 2 * (y*z - w*x);
                m[2][0] = 2 * (x*z - w*y);
                m[2][1] = 2 * (y*z + w*x);
                m[2][2] = w*w - x*x - y*y + z*z;
                acc = m[0][0]*bx + m[0][1]*by + m[0][2]*bz;
                o.r_x = round_sat(acc, 32, ovf);
                acc = m[1][0]*bx + m[1][1]*by + m[1][2]*bz;
                o.r_y = round_sat(acc, 32, ovf);
                acc = m[2][0]*bx + m[2][1]*by + m[2][2]*bz;
                o.r_z = round_sat(acc, 32, ovf);
            end
            CMD_SUM: begin
                o.r_w = round_sat(w + bw, 0, ovf);
                o.r_x = round_sat(x + bx, 0, ovf);
                o.r_y = round_sat(y + by, 0, ovf);
                o.r_z = round_sat(z + bz, 0, ovf);
            end
            CMD_DIFF: begin
                o.r_w = round_sat(w - bw, 0, ovf);
                o.r_x = round_sat(x - bx, 0, ovf);
                o.r_y = round_sat(y - by, 0, ovf);
                o.r_z = round_sat(z - bz, 0, ovf);
            end
            CMD_SCALE: begin
                o.r_w = round_sat(w * bw, 16, ovf);
                o.r_x = round_sat(x * bw, 16, ovf);
                o.r_y = round_sat(y * bw, 16, ovf);
                o.r_z = round_sat(z * bw, 16, ovf);
            end
            CMD_CONJ: begin
                o.r_w = c.a_w;
                o.r_x = round_sat(-x, 0, ovf);
                o.r_y = round_sat(-y, 0, ovf);
                o.r_z = round_sat(-z, 0, ovf);
            end
            CMD_DOT: begin
                o.r_w = round_sat(w*bw + x*bx + y*by + z*bz, 16, ovf);
            end
            default: begin
                sq = w*w + x*x + y*y + z*z;
                if (sq[127:64] != 0) begin
                    ovf = 1'b1;
                    o.r_w = 32'h7FFFFFFF;
                end else begin
                    root = floor_sqrt(sq);
                    if (root > 64'h7FFFFFFF) begin
                        ovf = 1'b1;
                        o.r_w = 32'h7FFFFFFF;
                    end else begin
                        o.r_w = root[31:0];
                    end
                end
            end
        endcase
        o.overflow = ovf;
        return o;
    endfunction

    // Print one mismatch line and count it
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("ERROR @%0d: %s got %h expected %h", cycle_count, what, got, want);
        err_count++;
    endtask

    // Random operand: extremes, small Q16.16 values, or full-range bits
    function automatic logic [31:0] rand_operand();
        int sel;
        sel = $urandom_range(0, 9);
        case (sel)
            0:       return 32'h7FFFFFFF;
            1:       return 32'h80000000;
            2, 3, 4: return 32'($signed($urandom_range(0, 32'h0007FFFF)) - 32'sh00040000);
            5, 6:    return 32'($signed($urandom_range(0, 32'h01FFFFFF)) - 32'sh01000000);
            default: return $urandom;
        endcase
    endfunction

    function automatic t_in_item rand_beat();
        t_in_item b;
        b.command = 3'($urandom_range(0, 7));
        b.a_w = rand_operand(); b.a_x = rand_operand();
        b.a_y = rand_operand(); b.a_z = rand_operand();
        b.b_w = rand_operand(); b.b_x = rand_operand();
        b.b_y = rand_operand(); b.b_z = rand_operand();
        return b;
    endfunction

    function automatic t_in_item mk_beat(input logic [2:0] cmd, input logic [31:0] av,
                                         input logic [31:0] bv);
        t_in_item b;
        b.command = cmd;
        b.a_w = av; b.a_x = av; b.a_y = av; b.a_z = av;
        b.b_w = bv; b.b_x = bv; b.b_y = bv; b.b_z = bv;
        return b;
    endfunction

    task automatic add_row(input t_in_item b, input logic has_exp, input t_out_item e);
        t_row r;
        r.beat = b;
        r.has_exp = has_exp;
        r.exp = e;
        rows.push_back(r);
    endtask

    // Offer one beat and hold it until accepted; idle first at the set rate
    task automatic send_beat(input t_in_item b);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= b;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        result_q.push_back(quat_predict(b));
        @(negedge i_clk);
    endtask

    // Build directed table: extremes, every command, special cases
    task automatic build_table();
        t_out_item e;
        t_in_item  b;
        // sum and difference saturating both ways
        e = '{32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 1'b1};
        add_row(mk_beat(CMD_SUM, 32'h7FFFFFFF, 32'h7FFFFFFF), 1'b1, e);
        e = '{32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 1'b1};
        add_row(mk_beat(CMD_SUM, 32'h80000000, 32'h80000000), 1'b1, e);
        add_row(mk_beat(CMD_DIFF, 32'h80000000, 32'h00000001), 1'b1, e);
        e = '{32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 1'b1};
        add_row(mk_beat(CMD_DIFF, 32'h7FFFFFFF, 32'hFFFFFFFF), 1'b1, e);
        // conjugate of the most negative value; scalar passes through
        e = '{32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 1'b1};
        add_row(mk_beat(CMD_CONJ, 32'h80000000, 32'h0), 1'b1, e);
        e = '{32'h00010000, 32'hFFFF0000, 32'hFFFF0000, 32'hFFFF0000, 1'b0};
        add_row(mk_beat(CMD_CONJ, 32'h00010000, 32'h0), 1'b1, e);
        // zero in, zero out
        e = '0;
        add_row(mk_beat(CMD_PRODUCT, 32'h0, 32'h0), 1'b1, e);
        add_row(mk_beat(CMD_ROTATE, 32'h0, 32'h0), 1'b1, e);
        add_row(mk_beat(CMD_NORM, 32'h0, 32'h0), 1'b1, e);
        add_row(mk_beat(CMD_DOT, 32'h0, 32'h7FFFFFFF), 1'b1, e);
        // norm of (1,1,1,1) is 2; norm of the extremes saturates
        e = '{32'h00020000, 32'h0, 32'h0, 32'h0, 1'b0};
        add_row(mk_beat(CMD_NORM, 32'h00010000, 32'h0), 1'b1, e);
        e = '{32'h7FFFFFFF, 32'h0, 32'h0, 32'h0, 1'b1};
        add_row(mk_beat(CMD_NORM, 32'h80000000, 32'h0), 1'b1, e);
        // scale by one, and extremes scaled into saturation
        b = mk_beat(CMD_SCALE, 32'h12345678, 32'h00010000);
        e = '{32'h12345678, 32'h12345678, 32'h12345678, 32'h12345678, 1'b0};
        add_row(b, 1'b1, e);
        add_row(mk_beat(CMD_SCALE, 32'h80000000, 32'h80000000), 1'b0, e);
        add_row(mk_beat(CMD_SCALE, 32'h7FFFFFFF, 32'h80000000), 1'b0, e);
        // rounding at half an LSB, positive and negative
        add_row(mk_beat(CMD_SCALE, 32'h00000001, 32'h00008000), 1'b0, e);
        add_row(mk_beat(CMD_SCALE, 32'hFFFFFFFF, 32'h00008000), 1'b0, e);
        add_row(mk_beat(CMD_DOT, 32'h7FFFFFFF, 32'h7FFFFFFF), 1'b0, e);
        add_row(mk_beat(CMD_DOT, 32'h80000000, 32'h7FFFFFFF), 1'b0, e);
        add_row(mk_beat(CMD_PRODUCT, 32'h80000000, 32'h80000000), 1'b0, e);
        add_row(mk_beat(CMD_PRODUCT, 32'h00010000, 32'h00020000), 1'b0, e);
        // identity rotation, non-identity unit rotation, overflowing rotation
        b = mk_beat(CMD_ROTATE, 32'h0, 32'h00030000);
        b.a_w = 32'h00010000;
        add_row(b, 1'b0, e);
        add_row(mk_beat(CMD_ROTATE, 32'h00008000, 32'hFFFE8000), 1'b0, e);
        add_row(mk_beat(CMD_ROTATE, 32'h7FFFFFFF, 32'h80000000), 1'b0, e);
    endtask

    // Drive directed rows, then random beats, in three idling phases
    task automatic run_stimulus();
        t_out_item p;
        build_table();
        foreach (rows[k]) begin
            p = quat_predict(rows[k].beat);
            if (rows[k].has_exp && p != rows[k].exp) begin
                $display("ERROR: table row %0d disagrees with predictor", k);
                err_count++;
            end
            send_beat(rows[k].beat);
        end
        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == N_RANDOM / 3) begin
                send_idle_pct = 58;
                recv_idle_pct = 12;
            end else if (n == 2 * N_RANDOM / 3) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            send_beat(rand_beat());
        end
        i_valid <= 1'b0;
    endtask

    // Receiver: random stall, with one long hold-off early in the run
    initial begin
        int hold_cnt;
        i_ready  = 1'b0;
        @(posedge i_rst_n);
        repeat (30) @(negedge i_clk);
        for (hold_cnt = 0; hold_cnt < 120; hold_cnt++) begin
            i_ready <= 1'b0;
            @(negedge i_clk);
        end
        forever begin
            i_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            @(negedge i_clk);
        end
    end

    // Check each result beat against the oldest expectation
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_valid && i_ready) begin
            if (result_q.size() == 0) begin
                $display("ERROR @%0d: result beat with none expected", cycle_count);
                err_count++;
            end else begin
                want = result_q.pop_front();
                if (o_data.r_w !== want.r_w) report_mismatch("r_w", o_data.r_w, want.r_w);
                if (o_data.r_x !== want.r_x) report_mismatch("r_x", o_data.r_x, want.r_x);
                if (o_data.r_y !== want.r_y) report_mismatch("r_y", o_data.r_y, want.r_y);
                if (o_data.r_z !== want.r_z) report_mismatch("r_z", o_data.r_z, want.r_z);
                if (o_data.overflow !== want.overflow) begin
                    report_mismatch("overflow", 32'(o_data.overflow), 32'(want.overflow));
                end
            end
        end
    end

    // Cycle limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Main sequence
    initial begin
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_data        = '0;
        err_count     = 0;
        cycle_count   = 0;
        send_idle_pct = 12;
        recv_idle_pct = 58;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        run_stimulus();
        while (result_q.size() != 0) @(negedge i_clk);
        repeat (60) @(negedge i_clk);
        if (err_count == 0 && result_q.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/qau_pkg.sv
hw/rtl/qau_front.sv
hw/rtl/qau_queue.sv
hw/rtl/qau_back.sv
hw/rtl/quaternion_arith_unit.sv
verif/tb_quaternion_arith_unit.sv
